### rtl/core/fixed_frame_sync_checksum_receiver_macros.svh
// Assertion helpers shared by the receiver modules.
// Every check is clocked on the rising edge and is switched off while reset is low.
`ifndef FIXED_FRAME_SYNC_CHECKSUM_RECEIVER_MACROS_SVH
`define FIXED_FRAME_SYNC_CHECKSUM_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFSC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define FFSC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

### rtl/core/ffsc_pkg.sv
`timescale 1ns / 1ps

package ffsc_pkg;

    typedef logic [7:0] byte_t;

    // Number of bytes in one frame, and the part held in registers between bytes.
    localparam int FRAME_LEN = 20;
    localparam int STORE_LEN = FRAME_LEN - 1;
    localparam int SUM_LEN   = 18;

    // Fill level at which the next byte completes a frame.
    localparam logic [4:0] FILL_LAST = 5'(STORE_LEN);

    localparam byte_t SYNC_RESET = 8'hAA;

    // Frame ids that produce a result.
    localparam byte_t ID_A_LO  = 8'hF0;
    localparam byte_t ID_A_HI  = 8'hF3;
    localparam byte_t ID_B_LO  = 8'hF8;
    localparam byte_t ID_B_HI  = 8'hFB;
    localparam byte_t ID_C_ONE = 8'hFE;
    localparam byte_t ID_C_TWO = 8'hFF;

    localparam int QUEUE_DEPTH = 4;

    // Packed with the first field in the highest bits, so frame_id lands at bit 0.
    typedef struct packed {
        logic [31:0] parsed_frames;
        logic [31:0] dropped_bytes;
        logic [63:0] payload_high;
        logic [63:0] payload_low;
        byte_t       frame_id;
    } result_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

endpackage

### rtl/core/ffsc_front.sv
`timescale 1ns / 1ps
`include "fixed_frame_sync_checksum_receiver_macros.svh"

module ffsc_front
    import ffsc_pkg::*;
#(
    parameter int COUNTER_BITS = 32
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  byte_t     sync_byte,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  byte_t     s_tdata,
    input  q_status_t q_status,
    output logic      push,
    output result_t   push_data
);

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    byte_t                   win_reg [STORE_LEN];
    logic [15:0]             sum_reg;
    logic [15:0]             sum_next;
    logic [4:0]              fill_reg;
    logic [4:0]              fill_next;
    logic [COUNTER_BITS-1:0] drop_reg;
    logic [COUNTER_BITS-1:0] drop_next;
    logic [COUNTER_BITS-1:0] parse_reg;
    logic [COUNTER_BITS-1:0] parse_next;
    logic [63:0]             drop_wide;
    logic [63:0]             parse_wide;
    logic                    accept;
    logic                    complete;
    logic                    frame_ok;
    logic                    id_reported;
    byte_t                   frame_id;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign complete = accept && (fill_reg == FILL_LAST);
    assign frame_id = win_reg[1];

    // The stored bytes are window positions 0..18; the arriving byte is position 19.
    assign frame_ok = (win_reg[0] == sync_byte) && (sum_reg == {s_tdata, win_reg[SUM_LEN]});

    always_comb begin
        id_reported = frame_id inside {[ID_A_LO:ID_A_HI], [ID_B_LO:ID_B_HI], ID_C_ONE, ID_C_TWO};
    end

    // Running sum of positions 0..17, kept up to date as the window shifts.
    assign sum_next = sum_reg - {8'h00, win_reg[0]} + {8'h00, win_reg[SUM_LEN]};

    always_comb begin
        fill_next  = fill_reg;
        drop_next  = drop_reg;
        parse_next = parse_reg;
        if (accept) begin
            if (!complete) begin
                fill_next = fill_reg + 5'd1;
            end else if (frame_ok) begin
                fill_next  = '0;
                parse_next = (parse_reg == CNT_MAX) ? parse_reg : parse_reg + 1'b1;
            end else begin
                drop_next = (drop_reg == CNT_MAX) ? drop_reg : drop_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STORE_LEN; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg   <= '0;
            fill_reg  <= '0;
            drop_reg  <= '0;
            parse_reg <= '0;
        end else begin
            if (accept) begin
                for (int i = 0; i < STORE_LEN - 1; i++) begin
                    win_reg[i] <= win_reg[i+1];
                end
                win_reg[STORE_LEN-1] <= s_tdata;
                sum_reg <= sum_next;
            end
            fill_reg  <= fill_next;
            drop_reg  <= drop_next;
            parse_reg <= parse_next;
        end
    end

    assign drop_wide  = 64'(drop_next);
    assign parse_wide = 64'(parse_next);

    assign push = complete && frame_ok && id_reported;

    always_comb begin
        push_data.frame_id      = frame_id;
        push_data.payload_low   = {win_reg[9], win_reg[8], win_reg[7], win_reg[6],
                                   win_reg[5], win_reg[4], win_reg[3], win_reg[2]};
        push_data.payload_high  = {win_reg[17], win_reg[16], win_reg[15], win_reg[14],
                                   win_reg[13], win_reg[12], win_reg[11], win_reg[10]};
        push_data.dropped_bytes = drop_wide[31:0];
        push_data.parsed_frames = parse_wide[31:0];
    end

    `FFSC_ASSERT_SAME(a_fill_in_range, aclk, aresetn, 1'b1, fill_reg <= FILL_LAST)
    `FFSC_ASSERT_NEXT(a_fill_steps, aclk, aresetn, accept && (fill_reg != FILL_LAST),
                      fill_reg == $past(fill_reg) + 5'd1)
    `FFSC_ASSERT_NEXT(a_drop_keeps_fill, aclk, aresetn, complete && !frame_ok,
                      fill_reg == FILL_LAST)

endmodule

### rtl/core/ffsc_queue.sv
`timescale 1ns / 1ps
`include "fixed_frame_sync_checksum_receiver_macros.svh"

module ffsc_queue
    import ffsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  result_t   push_data,
    input  logic      pop,
    output q_status_t status,
    output result_t   head
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    result_t             entries_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full      = (count_reg == CNT_FULL);
    assign status.not_empty = (count_reg != '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && status.not_empty;
    assign head    = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= PTR_BITS'((32'(wr_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            if (do_pop) begin
                rd_ptr_reg <= PTR_BITS'((32'(rd_ptr_reg) + 1) % QUEUE_DEPTH);
            end
            count_reg <= count_next;
        end
    end

    `FFSC_ASSERT_SAME(a_no_push_when_full, aclk, aresetn, status.full, !push)
    `FFSC_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)

endmodule

### rtl/core/ffsc_back.sv
`timescale 1ns / 1ps
`include "fixed_frame_sync_checksum_receiver_macros.svh"

module ffsc_back
    import ffsc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  q_status_t q_status,
    input  result_t   head,
    output logic      pop,
    output logic      m_tvalid,
    input  logic      m_tready,
    output result_t   m_tdata
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;

    // Refill the output register whenever it is empty or is being emptied.
    assign pop = q_status.not_empty && (!out_valid_reg || m_tready);

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_data_reg <= head;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `FFSC_ASSERT_NEXT(a_pop_fills_output, aclk, aresetn, pop, out_valid_reg)
    `FFSC_ASSERT_NEXT(a_idle_drains, aclk, aresetn, !q_status.not_empty && m_tready,
                      !out_valid_reg)

endmodule

### rtl/core/fixed_frame_sync_checksum_receiver.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// s_        in         s_tvalid / s_tready        s_tdata[7:0] rx_byte
// m_        out        m_tvalid / m_tready        m_tdata[199:0] result fields
// cfg_      in         cfg_valid / cfg_ready      cfg_data[7:0] sync_byte
//
// One byte is taken per cycle while s_tready is high; its frame check runs that cycle.
// A reported result goes into the queue, then into the output register driving m_tvalid.
// Bytes are taken back to back; the four-entry queue and output register only absorb stalls.
// Reset (aresetn low at a clock edge) empties the window, clears both counters,
// empties the queue and sets sync_byte to 0xAA; no clearing pass follows.
// s_tready drops only while the result queue is full, which needs m_tready held low.

module fixed_frame_sync_checksum_receiver
    import ffsc_pkg::*;
#(
    parameter int COUNTER_BITS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // [7:0] frame_id, [71:8] payload_low,
                                    // [135:72] payload_high, [167:136] dropped_bytes,
                                    // [199:168] parsed_frames
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data   // [7:0] sync_byte
);

    byte_t     sync_reg;
    q_status_t q_status;
    logic      push;
    result_t   push_data;
    logic      pop;
    result_t   head;
    result_t   out_data;

    // The sync byte register accepts a transfer in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= SYNC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            sync_reg <= cfg_data;
        end
    end

    // Front end: byte window, running checksum, frame classification and counters.
    ffsc_front #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .sync_byte (sync_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // Short queue so that a stalled output does not stop byte intake at once.
    ffsc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .status    (q_status),
        .head      (head)
    );

    // Back end: the registered output stage of the result channel.
    ffsc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (out_data)
    );

    assign m_tdata = out_data;

endmodule

### tb/tb_fixed_frame_sync_checksum_receiver.sv
`timescale 1ns / 1ps

module tb_fixed_frame_sync_checksum_receiver;
    import ffsc_pkg::*;

    // Counter width of the block as instantiated (its default).
    localparam int CNT_BITS    = 32;
    localparam int CYCLE_LIMIT = 200000;
    // Cycles allowed after the last expected transfer before the block counts as idle.
    localparam int SETTLE      = 8;

    // Payload patterns for generated frames.
    localparam int PAY_RANDOM = 0;
    localparam int PAY_ZERO   = 1;
    localparam int PAY_ONES   = 2;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata   = 8'h00;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [199:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_data  = 8'h00;

    // Bytes waiting to be offered on the input stream, and results still owed by the block.
    byte_t   rx_backlog[$];
    result_t frame_reports[$];
    int      bytes_queued = 0;
    int      mismatches   = 0;
    int      cycle_count  = 0;

    // Pacing controls set by the stimulus process.
    bit steady_phase = 1'b0;
    bit slow_sink    = 1'b0;

    // Shadow copy of the receiver's state.
    byte_t               win[FRAME_LEN];
    int                  win_fill    = 0;
    logic [CNT_BITS-1:0] drop_tally  = '0;
    logic [CNT_BITS-1:0] parse_tally = '0;
    byte_t               sync_now    = SYNC_RESET;

    result_t seen_result;
    result_t owed_result;

    fixed_frame_sync_checksum_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic bit id_is_reported(byte_t id);
        return (id >= ID_A_LO && id <= ID_A_HI) || (id >= ID_B_LO && id <= ID_B_HI) ||
               id == ID_C_ONE || id == ID_C_TWO;
    endfunction

    // Advances the shadow window by one received byte. A full window is either
    // consumed as a frame or slides by one byte, exactly as the hardware resynchronises.
    function automatic void absorb_rx_byte(byte_t b);
        logic [15:0] sum;
        logic [15:0] tail;
        result_t     r;
        int          i;
        if (win_fill < FRAME_LEN) begin
            win[win_fill] = b;
            win_fill++;
        end
        if (win_fill < FRAME_LEN)
            return;
        sum = '0;
        for (i = 0; i < SUM_LEN; i++)
            sum += win[i];
        tail = {win[FRAME_LEN-1], win[FRAME_LEN-2]};
        if (win[0] != sync_now || sum != tail) begin
            for (i = 0; i < FRAME_LEN - 1; i++)
                win[i] = win[i+1];
            win_fill = FRAME_LEN - 1;
            if (drop_tally != '1)
                drop_tally++;
            return;
        end
        win_fill = 0;
        if (parse_tally != '1)
            parse_tally++;
        if (!id_is_reported(win[1]))
            return;
        r.frame_id = win[1];
        for (i = 0; i < 8; i++) begin
            r.payload_low[8*i +: 8]  = win[2+i];
            r.payload_high[8*i +: 8] = win[10+i];
        end
        r.dropped_bytes = 32'(drop_tally);
        r.parsed_frames = 32'(parse_tally);
        frame_reports.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Queues a 20-byte frame; a broken checksum has one bit of the trailer flipped.
    task automatic push_frame(byte_t head, byte_t id, int pattern, bit break_sum);
        byte_t       body[FRAME_LEN];
        logic [15:0] sum;
        int          i;
        body[0] = head;
        body[1] = id;
        for (i = 2; i < SUM_LEN; i++)
            body[i] = (pattern == PAY_ZERO) ? 8'h00 :
                      (pattern == PAY_ONES) ? 8'hFF : byte_t'($urandom);
        sum = '0;
        for (i = 0; i < SUM_LEN; i++)
            sum += body[i];
        if (break_sum)
            sum ^= 16'(1) << $urandom_range(0, 15);
        body[SUM_LEN]   = sum[7:0];
        body[SUM_LEN+1] = sum[15:8];
        for (i = 0; i < FRAME_LEN; i++)
            rx_backlog.push_back(body[i]);
        bytes_queued += FRAME_LEN;
    endtask

    // Waits until every queued byte has been taken and every owed result has
    // arrived, then lets the output pipeline drain before anything else happens.
    task automatic wait_until_quiet();
        while (rx_backlog.size() != 0 || s_tvalid || frame_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_sync_byte(byte_t value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sync_now = value;
    endtask

    // Input side. A transfer completes at an edge where tvalid and tready are both
    // high; the shadow model absorbs that byte at the same edge. A new byte is only
    // offered once the previous one has gone, and about a third of the slots stay
    // empty unless the phase runs without gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                absorb_rx_byte(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (rx_backlog.size() != 0 && (steady_phase || $urandom_range(0, 99) >= 36)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= rx_backlog.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side. Each result transfer is compared field by field with the oldest
    // owed result. tready idles at random, holds high in the steady phase and is
    // mostly low in the slow phase so that the result queue fills and the block
    // has to push back on its input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_result = result_t'(m_tdata);
                if (frame_reports.size() == 0) begin
                    report_mismatch("result with none owed, frame_id", seen_result.frame_id, 0);
                end else begin
                    owed_result = frame_reports.pop_front();
                    if (seen_result.frame_id != owed_result.frame_id)
                        report_mismatch("frame_id", seen_result.frame_id,
                                        owed_result.frame_id);
                    if (seen_result.payload_low != owed_result.payload_low)
                        report_mismatch("payload_low", seen_result.payload_low,
                                        owed_result.payload_low);
                    if (seen_result.payload_high != owed_result.payload_high)
                        report_mismatch("payload_high", seen_result.payload_high,
                                        owed_result.payload_high);
                    if (seen_result.dropped_bytes != owed_result.dropped_bytes)
                        report_mismatch("dropped_bytes", seen_result.dropped_bytes,
                                        owed_result.dropped_bytes);
                    if (seen_result.parsed_frames != owed_result.parsed_frames)
                        report_mismatch("parsed_frames", seen_result.parsed_frames,
                                        owed_result.parsed_frames);
                end
            end
            if (steady_phase)
                m_tready <= 1'b1;
            else if (slow_sink)
                m_tready <= ($urandom_range(0, 99) < 15);
            else
                m_tready <= ($urandom_range(0, 99) >= 36);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[fixed_frame_sync_checksum_receiver] ERROR");
        $finish;
    end

    initial begin
        byte_t settings[5];
        byte_t head;
        byte_t id;
        int    phase;
        int    phase_start;
        int    pick;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening with the reset sync byte: a little leading noise,
        // including a false sync byte, must be dropped before a clean frame lines up.
        rx_backlog.push_back(8'h00);
        rx_backlog.push_back(8'hFF);
        rx_backlog.push_back(SYNC_RESET);
        bytes_queued += 3;
        push_frame(SYNC_RESET, ID_A_LO, PAY_ZERO, 1'b0);
        wait_until_quiet();

        settings[0] = 8'h00;
        settings[1] = 8'hFF;
        settings[2] = byte_t'($urandom);
        settings[3] = 8'h5A;
        settings[4] = SYNC_RESET;

        for (phase = 0; phase < 5; phase++) begin
            write_sync_byte(settings[phase]);
            steady_phase = (phase == 1);
            slow_sink    = (phase == 3);
            phase_start  = bytes_queued;

            // Payload extremes, two reported ids and one silent id.
            push_frame(sync_now, ID_C_TWO, PAY_ONES, 1'b0);
            push_frame(sync_now, ID_A_HI, PAY_ZERO, 1'b0);
            push_frame(sync_now, ID_B_LO - 8'd1, PAY_ONES, 1'b0);

            // Mostly well-formed frames with random content; the rest are frames
            // with a bad checksum or a bad header, and loose noise bytes.
            while (bytes_queued - phase_start < 255) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 3))
                    0: id = ID_A_LO + byte_t'($urandom_range(0, 3));
                    1: id = ID_B_LO + byte_t'($urandom_range(0, 3));
                    2: id = ($urandom_range(0, 1) != 0) ? ID_C_ONE : ID_C_TWO;
                    default: id = byte_t'($urandom);
                endcase
                if (pick < 68) begin
                    push_frame(sync_now, id, PAY_RANDOM, 1'b0);
                end else if (pick < 78) begin
                    push_frame(sync_now, id, PAY_RANDOM, 1'b1);
                end else if (pick < 86) begin
                    head = sync_now ^ byte_t'($urandom_range(1, 255));
                    push_frame(head, id, PAY_RANDOM, 1'b0);
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        rx_backlog.push_back(($urandom_range(0, 3) == 0) ?
                                             sync_now : byte_t'($urandom));
                        bytes_queued++;
                    end
                end
            end
            // The sender holds off here until every owed result has been seen.
            wait_until_quiet();
        end

        steady_phase = 1'b0;
        slow_sink    = 1'b0;
        wait_until_quiet();

        if (mismatches == 0)
            $display("[fixed_frame_sync_checksum_receiver] OK");
        else
            $display("[fixed_frame_sync_checksum_receiver] ERROR");
        $finish;
    end

endmodule
